FILE: sv/kf2_pkg.sv
// Shared types, operation codes and command encodings for the two-state Kalman filter.
package kf2_pkg;

    // Item operation codes carried by the mode field.
    localparam logic [1:0] MODE_PREDICT = 2'd0;
    localparam logic [1:0] MODE_UPDATE  = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_PLANT_NOISE   = 2'd0;
    localparam logic [1:0] REG_SENSOR_NOISE  = 2'd1;
    localparam logic [1:0] REG_INITIAL_ERROR = 2'd2;

    // Register file addresses inside the datapath.
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_BITS = 4;
    typedef logic [SLOT_BITS-1:0] slot_t;

    localparam slot_t R_SPD  = 4'd0;
    localparam slot_t R_RAT  = 4'd1;
    localparam slot_t R_P0   = 4'd2;
    localparam slot_t R_P1   = 4'd3;
    localparam slot_t R_P2   = 4'd4;
    localparam slot_t R_P3   = 4'd5;
    localparam slot_t R_DT   = 4'd6;
    localparam slot_t R_Z    = 4'd7;
    localparam slot_t R_H    = 4'd8;
    localparam slot_t R_T0   = 4'd9;
    localparam slot_t R_T1   = 4'd10;
    localparam slot_t R_T2   = 4'd11;
    localparam slot_t R_T3   = 4'd12;
    localparam slot_t R_T4   = 4'd13;
    localparam slot_t R_Q    = 4'd14;
    localparam slot_t R_ONE  = 4'd15;

    // Datapath operations.
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_HALF = 3'd4;
    localparam logic [2:0] OP_MOV  = 3'd5;
    localparam logic [2:0] OP_ZERO = 3'd6;
    localparam logic [2:0] OP_SFLR = 3'd7;

    // One microinstruction: dst = a op b.
    typedef struct packed {
        logic [2:0] op;
        slot_t      dst;
        slot_t      src_a;
        slot_t      src_b;
    } uop_t;

    // Controller to datapath.
    typedef struct packed {
        logic  load;   // capture item fields and constants
        logic  start;  // begin the microinstruction in uop
        uop_t  uop;
    } kf2_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic done;    // the started microinstruction has written back
    } kf2_sts_t;

    localparam int PROG_LEN = 32;
    localparam int PC_BITS  = 5;

    // Microprograms; a program ends with the first OP_ZERO to R_ONE marker.
    function automatic uop_t mk(logic [2:0] op, slot_t d, slot_t a, slot_t b);
        uop_t u;
        u.op = op; u.dst = d; u.src_a = a; u.src_b = b;
        return u;
    endfunction

    localparam uop_t END_UOP = '{op: OP_ZERO, dst: R_ONE, src_a: R_ONE, src_b: R_ONE};

    function automatic uop_t prog_predict(logic [PC_BITS-1:0] pc);
        uop_t u;
        u = END_UOP;
        case (pc)
            5'd0:  u = mk(OP_MUL, R_T0, R_P2, R_DT);
            5'd1:  u = mk(OP_ADD, R_T0, R_P0, R_T0);   // fp0
            5'd2:  u = mk(OP_MUL, R_T1, R_P3, R_DT);
            5'd3:  u = mk(OP_ADD, R_T2, R_P1, R_T1);   // fp1
            5'd4:  u = mk(OP_MUL, R_T3, R_RAT, R_DT);
            5'd5:  u = mk(OP_ADD, R_SPD, R_SPD, R_T3);
            5'd6:  u = mk(OP_MUL, R_T3, R_T2, R_DT);
            5'd7:  u = mk(OP_ADD, R_T0, R_T0, R_T3);
            5'd8:  u = mk(OP_ADD, R_P0, R_T0, R_Q);
            5'd9:  u = mk(OP_MOV, R_P1, R_T2, R_T2);
            5'd10: u = mk(OP_ADD, R_P2, R_P2, R_T1);
            5'd11: u = mk(OP_ADD, R_P3, R_P3, R_Q);
            default: u = END_UOP;
        endcase
        return u;
    endfunction

    // R_Q holds the sensor noise during an update.
    function automatic uop_t prog_update(logic [PC_BITS-1:0] pc);
        uop_t u;
        u = END_UOP;
        case (pc)
            5'd0:  u = mk(OP_SFLR, R_T0, R_P0, R_Q);   // S with floor
            5'd1:  u = mk(OP_DIV, R_T1, R_P0, R_T0);   // k0
            5'd2:  u = mk(OP_DIV, R_T2, R_P2, R_T0);   // k1
            5'd3:  u = mk(OP_SUB, R_T3, R_Z, R_SPD);   // y
            5'd4:  u = mk(OP_MUL, R_T4, R_T1, R_T3);
            5'd5:  u = mk(OP_ADD, R_SPD, R_SPD, R_T4);
            5'd6:  u = mk(OP_MUL, R_T4, R_T2, R_T3);
            5'd7:  u = mk(OP_ADD, R_RAT, R_RAT, R_T4);
            5'd8:  u = mk(OP_SUB, R_T1, R_ONE, R_T1);  // 1 - k0
            5'd9:  u = mk(OP_MUL, R_T3, R_T2, R_P0);
            5'd10: u = mk(OP_SUB, R_P2, R_P2, R_T3);
            5'd11: u = mk(OP_MUL, R_T3, R_T2, R_P1);
            5'd12: u = mk(OP_SUB, R_P3, R_P3, R_T3);
            5'd13: u = mk(OP_MUL, R_P0, R_T1, R_P0);
            5'd14: u = mk(OP_MUL, R_P1, R_T1, R_P1);
            default: u = END_UOP;
        endcase
        return u;
    endfunction

    // R_Q holds the initial error during a restart.
    function automatic uop_t prog_restart(logic [PC_BITS-1:0] pc);
        uop_t u;
        u = END_UOP;
        case (pc)
            5'd0: u = mk(OP_ZERO, R_SPD, R_SPD, R_SPD);
            5'd1: u = mk(OP_ZERO, R_RAT, R_RAT, R_RAT);
            5'd2: u = mk(OP_MOV, R_P0, R_Q, R_Q);
            5'd3: u = mk(OP_ZERO, R_P1, R_P1, R_P1);
            5'd4: u = mk(OP_ZERO, R_P2, R_P2, R_P2);
            5'd5: u = mk(OP_MOV, R_P3, R_Q, R_Q);
            default: u = END_UOP;
        endcase
        return u;
    endfunction

    // Look-ahead program, run after every operation.
    function automatic uop_t prog_look(logic [PC_BITS-1:0] pc);
        uop_t u;
        u = END_UOP;
        case (pc)
            5'd0: u = mk(OP_MUL, R_T0, R_SPD, R_H);
            5'd1: u = mk(OP_MUL, R_T1, R_RAT, R_H);
            5'd2: u = mk(OP_MUL, R_T1, R_T1, R_H);
            5'd3: u = mk(OP_HALF, R_T1, R_T1, R_T1);
            5'd4: u = mk(OP_ADD, R_T0, R_T0, R_T1);
            default: u = END_UOP;
        endcase
        return u;
    endfunction

endpackage

FILE: sv/kf2_datapath.sv
// Datapath: register slots, saturating adder, multiplier and serial divider.
module kf2_datapath #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kf2_pkg::kf2_cmd_t    cmd,
    output kf2_pkg::kf2_sts_t    sts,
    input  logic [1:0]           mode,
    input  logic [30:0]          step_time,
    input  logic signed [31:0]   measurement,
    input  logic [30:0]          horizon,
    input  logic [30:0]          plant_noise,
    input  logic [30:0]          sensor_noise,
    input  logic [30:0]          initial_error,
    output logic signed [31:0]   speed,
    output logic signed [31:0]   rate,
    output logic signed [31:0]   angle_delta
);
    import kf2_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int W2  = 2 * WORD_BITS;
    localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] UMAX = {1'b0, {(W-1){1'b1}}};

    // Saturate an unsigned 31-bit field to the word.
    function automatic logic signed [W-1:0] fit31(logic [30:0] v);
        logic [63:0] e;
        e = {33'd0, v};
        if (e > {{(64-W){1'b0}}, UMAX}) return WMAX;
        return W'(e);
    endfunction

    // Saturate a signed 32-bit field to the word.
    function automatic logic signed [W-1:0] fit32(logic signed [31:0] v);
        logic signed [64:0] e;
        e = 65'(v);
        if (e > 65'(WMAX)) return WMAX;
        if (e < 65'(WMIN)) return WMIN;
        return W'(e);
    endfunction

    function automatic logic signed [31:0] out32(logic signed [W-1:0] v);
        logic signed [64:0] e;
        e = 65'(v);
        if (e > 65'sd2147483647) return 32'sh7FFFFFFF;
        if (e < -65'sd2147483648) return 32'sh80000000;
        return e[31:0];
    endfunction

    function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] a,
                                                    logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(logic signed [W-1:0] a,
                                                    logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    // Saturate a sign and a magnitude to the word.
    function automatic logic signed [W-1:0] sat_mag(logic neg, logic [W2+FRAC_BITS-1:0] m);
        if (neg) begin
            if (m > (W2+FRAC_BITS)'(UMAX) + 1'b1) return WMIN;
            return W'(-$signed({1'b0, m}));
        end
        if (m > (W2+FRAC_BITS)'(UMAX)) return WMAX;
        return W'(m);
    endfunction

    logic signed [W-1:0] slot_reg [NUM_SLOTS];
    logic signed [W-1:0] a_val, b_val;
    logic [W-1:0]        a_mag, b_mag;

    assign a_val = slot_reg[cmd.uop.src_a];
    assign b_val = slot_reg[cmd.uop.src_b];
    assign a_mag = a_val[W-1] ? W'(-a_val) : W'(a_val);
    assign b_mag = b_val[W-1] ? W'(-b_val) : W'(b_val);

    // Multiplier: operand magnitudes registered, product registered, then scaled.
    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_PROD = 2'd1;
    localparam logic [1:0] M_SAT  = 2'd2;
    logic [1:0]      mstate_reg, mstate_next;
    logic [W2-1:0]   prod_reg;
    logic            neg_reg;

    // Divider: restoring, one quotient bit per cycle.
    logic                          div_busy_reg;
    logic [CNT_BITS-1:0]           div_cnt_reg;
    logic [W+FRAC_BITS-1:0]        div_num_reg;
    logic [W:0]                    div_rem_reg;
    logic [W+FRAC_BITS-1:0]        div_q_reg;
    logic [W-1:0]                  div_den_reg;
    logic [W:0]                    rem_shift;
    logic                          div_last;

    assign rem_shift = {div_rem_reg[W-1:0], div_num_reg[W+FRAC_BITS-1]};
    assign div_last  = (div_cnt_reg == CNT_BITS'(DIV_STEPS - 1));

    logic signed [W-1:0] s_val, alu_res;
    logic                wr_en;
    logic signed [W-1:0] wr_data;

    // Combinational ALU results.
    always_comb
    begin
        s_val = sat_add(a_val, b_val);
        alu_res = '0;
        case (cmd.uop.op)
            OP_ADD:  alu_res = s_val;
            OP_SUB:  alu_res = sat_sub(a_val, b_val);
            OP_HALF: alu_res = a_val[W-1] ? W'(-$signed({1'b0, a_mag >> 1}))
                                          : W'(a_mag >> 1);
            OP_MOV:  alu_res = a_val;
            OP_ZERO: alu_res = '0;
            OP_SFLR: alu_res = (s_val == '0) ? W'(1) : s_val;
            default: alu_res = '0;
        endcase
    end

    // Write back and done generation.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = alu_res;
        mstate_next = mstate_reg;
        case (mstate_reg)
            M_IDLE:  if (cmd.start && cmd.uop.op == OP_MUL) mstate_next = M_PROD;
            M_PROD:  mstate_next = M_SAT;
            M_SAT:   mstate_next = M_IDLE;
            default: mstate_next = M_IDLE;
        endcase
        if (cmd.start && cmd.uop.op != OP_MUL && cmd.uop.op != OP_DIV) begin
            wr_en = 1'b1;
        end else if (mstate_reg == M_SAT) begin
            wr_en   = 1'b1;
            wr_data = sat_mag(neg_reg, (W2+FRAC_BITS)'(prod_reg >> FRAC_BITS));
        end else if (div_busy_reg && div_last) begin
            wr_en   = 1'b1;
            wr_data = sat_mag(neg_reg, (W2+FRAC_BITS)'(
                {div_q_reg[W+FRAC_BITS-2:0], (rem_shift >= {1'b0, div_den_reg})}));
        end
    end

    assign sts.done = wr_en;

    logic [W-1:0] ma_reg, mb_reg;
    slot_t        dst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mstate_reg   <= M_IDLE;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            mstate_reg <= mstate_next;
            if (cmd.start && cmd.uop.op == OP_DIV) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_last) div_busy_reg <= 1'b0;
            end
        end
    end

    // The filter state loads its reset value on every clock until reset release is seen.
    logic rst_n_seen_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rst_n_seen_reg <= 1'b0;
        else        rst_n_seen_reg <= 1'b1;
    end

    // Payload registers of the arithmetic units and register slots.
    always_ff @(posedge clk)
    begin
        if (cmd.start) begin
            dst_reg <= cmd.uop.dst;
            neg_reg <= a_val[W-1] ^ b_val[W-1];
            ma_reg  <= a_mag;
            mb_reg  <= b_mag;
        end
        if (mstate_reg == M_PROD) prod_reg <= W2'(ma_reg) * W2'(mb_reg);
        if (cmd.start && cmd.uop.op == OP_DIV) begin
            div_num_reg <= {a_mag, {FRAC_BITS{1'b0}}};
            div_den_reg <= b_mag;
            div_rem_reg <= '0;
            div_q_reg   <= '0;
        end else if (div_busy_reg) begin
            div_num_reg <= div_num_reg << 1;
            if (rem_shift >= {1'b0, div_den_reg}) begin
                div_rem_reg <= rem_shift - {1'b0, div_den_reg};
                div_q_reg   <= {div_q_reg[W+FRAC_BITS-2:0], 1'b1};
            end else begin
                div_rem_reg <= rem_shift;
                div_q_reg   <= {div_q_reg[W+FRAC_BITS-2:0], 1'b0};
            end
        end
        if (cmd.load) begin
            slot_reg[R_DT]  <= fit31(step_time);
            slot_reg[R_Z]   <= fit32(measurement);
            slot_reg[R_H]   <= fit31(horizon);
            slot_reg[R_ONE] <= fit31(31'(1) << FRAC_BITS);
            case (mode)
                MODE_UPDATE:  slot_reg[R_Q] <= fit31(sensor_noise);
                MODE_RESTART: slot_reg[R_Q] <= fit31(initial_error);
                default:      slot_reg[R_Q] <= fit31(plant_noise);
            endcase
        end
        if (wr_en) begin
            if (cmd.start) slot_reg[cmd.uop.dst] <= wr_data;
            else           slot_reg[dst_reg] <= wr_data;
        end
        if (!rst_n_seen_reg) begin
            slot_reg[R_SPD] <= '0;
            slot_reg[R_RAT] <= '0;
            slot_reg[R_P0]  <= fit31(31'(1) << FRAC_BITS);
            slot_reg[R_P1]  <= '0;
            slot_reg[R_P2]  <= '0;
            slot_reg[R_P3]  <= fit31(31'(1) << FRAC_BITS);
        end
    end

    assign speed       = out32(slot_reg[R_SPD]);
    assign rate        = out32(slot_reg[R_RAT]);
    assign angle_delta = out32(slot_reg[R_T0]);

endmodule

FILE: sv/kf2_ctrl.sv
// Controller: sequences microprograms for one item and runs both handshakes.
module kf2_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    output logic                out_valid,
    input  logic                out_stall,
    output kf2_pkg::kf2_cmd_t   cmd,
    input  kf2_pkg::kf2_sts_t   sts
);
    import kf2_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_LOOK  = 3'd4;
    localparam logic [2:0] S_LWAIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic [1:0]         mode_reg;
    uop_t               uop;
    logic               accept;
    logic               multi;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Multiply and divide write back later; every other operation writes at issue.
    assign multi = (uop.op == OP_MUL) || (uop.op == OP_DIV);

    // Select the current microinstruction.
    always_comb
    begin
        uop = END_UOP;
        if (state_reg == S_LOOK || state_reg == S_LWAIT) uop = prog_look(pc_reg);
        else begin
            case (mode_reg)
                MODE_PREDICT: uop = prog_predict(pc_reg);
                MODE_UPDATE:  uop = prog_update(pc_reg);
                MODE_RESTART: uop = prog_restart(pc_reg);
                default:      uop = END_UOP;
            endcase
        end
    end

    // Sequencing.
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cmd.load   = accept;
        cmd.start  = 1'b0;
        cmd.uop    = uop;
        case (state_reg)
            S_INIT: state_next = S_IDLE;
            S_IDLE: if (accept) begin
                state_next = S_ISSUE;
                pc_next    = '0;
            end
            S_ISSUE: if (uop == END_UOP) begin
                state_next = S_LOOK;
                pc_next    = '0;
            end else begin
                cmd.start  = 1'b1;
                if (multi) state_next = S_WAIT;
                else       pc_next    = pc_reg + 1'b1;
            end
            S_WAIT: if (sts.done) begin
                state_next = S_ISSUE;
                pc_next    = pc_reg + 1'b1;
            end
            S_LOOK: if (uop == END_UOP) state_next = S_OUT;
                    else begin
                        cmd.start  = 1'b1;
                        if (multi) state_next = S_LWAIT;
                        else       pc_next    = pc_reg + 1'b1;
                    end
            S_LWAIT: if (sts.done) begin
                state_next = S_LOOK;
                pc_next    = pc_reg + 1'b1;
            end
            S_OUT: if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_INIT;
            pc_reg    <= '0;
            mode_reg  <= MODE_PREDICT;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (accept) mode_reg <= mode;
        end
    end

endmodule

FILE: sv/kalman_filter_two_state_top.sv
// Top level of the two-state Kalman filter: config registers, controller and datapath.
// One item at a time. Update is the slowest mode, mostly because of its two quotients
// on the restoring divider, which produces one quotient bit per cycle, and every
// multiply runs on the shared multiplier. A result holds on the outputs while stalled;
// the next item is taken once the result leaves. Configuration must be written only
// while idle; the block itself does not enforce this.
module kalman_filter_two_state_top #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [30:0]        step_time,
    input  logic signed [31:0] measurement,
    input  logic [30:0]        horizon,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] speed,
    output logic signed [31:0] rate,
    output logic signed [31:0] angle_delta,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import kf2_pkg::*;

    logic [30:0] plant_noise_reg, sensor_noise_reg, initial_error_reg;
    kf2_cmd_t    cmd;
    kf2_sts_t    sts;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            plant_noise_reg   <= 31'd655;
            sensor_noise_reg  <= 31'd65536;
            initial_error_reg <= 31'd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PLANT_NOISE:   plant_noise_reg   <= cfg_data[30:0];
                REG_SENSOR_NOISE:  sensor_noise_reg  <= cfg_data[30:0];
                REG_INITIAL_ERROR: initial_error_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    kf2_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .sts(sts)
    );

    kf2_datapath #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .mode(mode), .step_time(step_time), .measurement(measurement),
        .horizon(horizon),
        .plant_noise(plant_noise_reg), .sensor_noise(sensor_noise_reg),
        .initial_error(initial_error_reg),
        .speed(speed), .rate(rate), .angle_delta(angle_delta)
    );

endmodule

FILE: sv/kf2_checker.sv
// Port-level checker for the two-state Kalman filter, bound to the top level.
module kf2_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] speed
);
    // A result appears only while no new item can enter.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("result shown while input open");

    // An accepted item blocks the input in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall) else $error("input not closed");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(speed)))
        else $error("stalled result changed");

    // No result directly after an accepted item.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
endmodule

bind kalman_filter_two_state_top kf2_checker u_kf2_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .speed(speed)
);

FILE: dv/tb.sv
// Self-checking testbench for the two-state Kalman filter top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kf2_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd65536;
    localparam int HANG_LIMIT = 20000;

    typedef struct {
        logic [1:0]         mode;
        logic [30:0]        step_time;
        logic signed [31:0] measurement;
        logic [30:0]        horizon;
    } filter_item_t;

    typedef struct {
        logic signed [31:0] speed;
        logic signed [31:0] rate;
        logic signed [31:0] angle_delta;
    } estimate_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] mode;
    logic [30:0] step_time;
    logic signed [31:0] measurement;
    logic [30:0] horizon;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] speed;
    logic signed [31:0] rate;
    logic signed [31:0] angle_delta;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    kalman_filter_two_state_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .step_time(step_time), .measurement(measurement), .horizon(horizon),
        .out_valid(out_valid), .out_stall(out_stall),
        .speed(speed), .rate(rate), .angle_delta(angle_delta),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state and register copies.
    longint pred_speed;
    longint pred_rate;
    longint pred_cov[4];
    longint noise_q;
    longint noise_r;
    longint init_err;

    filter_item_t pending_items[$];
    estimate_t expected_estimates[$];
    int errors;
    int accepted_items;
    int checked_results;
    int idle_cycles;
    bit no_idle;
    int hold_off;
    int op_count[4];
    int floor_hits;

    // Saturating fixed-point helpers.
    function automatic longint sat(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint q_add(longint a, longint b);
        return sat(a + b);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return sat(a - b);
    endfunction

    // Full product truncated toward zero on the magnitude.
    function automatic longint q_mul(longint a, longint b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] pr;
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        pr = (ma * mb) >> 16;
        if (pr > 128'(WMAX)) return ((a < 0) != (b < 0)) ? WMIN : WMAX;
        return ((a < 0) != (b < 0)) ? -longint'(pr) : longint'(pr);
    endfunction

    function automatic longint q_div(longint a, longint b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] qt;
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        qt = (ma << 16) / mb;
        if (qt > 128'(WMAX)) return ((a < 0) != (b < 0)) ? WMIN : WMAX;
        return ((a < 0) != (b < 0)) ? -longint'(qt) : longint'(qt);
    endfunction

    function automatic longint q_half(longint m);
        return (m < 0) ? -((-m) >>> 1) : (m >>> 1);
    endfunction

    // Advance the predictor by one item and return the expected estimate.
    function automatic estimate_t filter_step(filter_item_t it);
        estimate_t e;
        longint dt, z, h, p0, p1, p2, p3, fp0, fp1, s, k0, k1, y, omk;
        dt = longint'(it.step_time);
        z = longint'(it.measurement);
        h = longint'(it.horizon);
        p0 = pred_cov[0];
        p1 = pred_cov[1];
        p2 = pred_cov[2];
        p3 = pred_cov[3];
        case (it.mode)
            MODE_PREDICT:
            begin
                fp0 = q_add(p0, q_mul(p2, dt));
                fp1 = q_add(p1, q_mul(p3, dt));
                pred_speed = q_add(pred_speed, q_mul(pred_rate, dt));
                pred_cov[0] = q_add(q_add(fp0, q_mul(fp1, dt)), noise_q);
                pred_cov[1] = fp1;
                pred_cov[2] = q_add(p2, q_mul(p3, dt));
                pred_cov[3] = q_add(p3, noise_q);
            end
            MODE_UPDATE:
            begin
                s = q_add(p0, noise_r);
                // A zero innovation is floored to one LSB to avoid a zero divisor.
                if (s == 0)
                begin
                    s = 1;
                    floor_hits++;
                end
                k0 = q_div(p0, s);
                k1 = q_div(p2, s);
                y = q_sub(z, pred_speed);
                pred_speed = q_add(pred_speed, q_mul(k0, y));
                pred_rate = q_add(pred_rate, q_mul(k1, y));
                omk = q_sub(ONE_Q, k0);
                pred_cov[0] = q_mul(omk, p0);
                pred_cov[1] = q_mul(omk, p1);
                pred_cov[2] = q_sub(p2, q_mul(k1, p0));
                pred_cov[3] = q_sub(p3, q_mul(k1, p1));
            end
            MODE_RESTART:
            begin
                pred_speed = 0;
                pred_rate = 0;
                pred_cov[0] = init_err;
                pred_cov[1] = 0;
                pred_cov[2] = 0;
                pred_cov[3] = init_err;
            end
            default:
            begin
            end
        endcase
        e.speed = 32'(pred_speed);
        e.rate = 32'(pred_rate);
        e.angle_delta = 32'(q_add(q_mul(pred_speed, h),
                                  q_half(q_mul(q_mul(pred_rate, h), h))));
        return e;
    endfunction

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    logic in_accept;

    // Sample the input handshake at the rising edge.
    always @(posedge clk)
    begin
        in_accept <= rst_n && in_valid && !in_stall;
    end

    // Input side: after an accepted item, pop it and maybe offer the next one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_accept)
            begin
                op_count[mode]++;
                accepted_items++;
                void'(pending_items.pop_front());
            end
            if ((!in_valid || in_accept) && pending_items.size() > 0
                && (no_idle || $urandom_range(99) >= 21))
            begin
                in_valid <= 1'b1;
                mode <= pending_items[0].mode;
                step_time <= pending_items[0].step_time;
                measurement <= pending_items[0].measurement;
                horizon <= pending_items[0].horizon;
                expected_estimates.push_back(filter_step(pending_items[0]));
            end
            else if (in_accept || !in_valid)
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side: random stall plus an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !no_idle && ($urandom_range(99) < 21);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_estimates.size() == 0)
            begin
                $display("%0t: unexpected result speed=%0d rate=%0d angle=%0d",
                         $realtime, speed, rate, angle_delta);
                errors++;
            end
            else
            begin
                if (speed !== expected_estimates[0].speed)
                begin
                    $display("%0t: speed expected %0d actual %0d", $realtime,
                             expected_estimates[0].speed, speed);
                    errors++;
                end
                if (rate !== expected_estimates[0].rate)
                begin
                    $display("%0t: rate expected %0d actual %0d", $realtime,
                             expected_estimates[0].rate, rate);
                    errors++;
                end
                if (angle_delta !== expected_estimates[0].angle_delta)
                begin
                    $display("%0t: angle_delta expected %0d actual %0d", $realtime,
                             expected_estimates[0].angle_delta, angle_delta);
                    errors++;
                end
                void'(expected_estimates.pop_front());
                checked_results++;
            end
        end
    end

    // Watchdog on cycles without any accepted item, taken result or configuration write.
    always @(posedge clk)
    begin
        if ((rst_n && in_valid && !in_stall) || (rst_n && out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, HANG_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    // Random item with mostly moderate magnitudes, occasional extremes and a rare unused mode.
    function automatic filter_item_t rand_item();
        filter_item_t it;
        int sel;
        it.mode = 2'($urandom_range(99) < 45 ? MODE_PREDICT :
                     ($urandom_range(99) < 85 ? MODE_UPDATE : MODE_RESTART));
        if ($urandom_range(99) < 2)
        begin
            it.mode = 2'd3;
        end
        sel = $urandom_range(9);
        it.step_time = (sel == 0) ? 31'($urandom) : 31'($urandom_range(32768));
        sel = $urandom_range(9);
        it.measurement = (sel < 2) ? 32'($urandom) : 32'($urandom_range(2000000)) - 32'd1000000;
        sel = $urandom_range(9);
        it.horizon = (sel == 0) ? 31'($urandom) : 31'($urandom_range(131072));
        return it;
    endfunction

    function automatic filter_item_t mk_item(logic [1:0] m, logic [30:0] dt,
                                            logic signed [31:0] z, logic [30:0] h);
        filter_item_t it;
        it.mode = m;
        it.step_time = dt;
        it.measurement = z;
        it.horizon = h;
        return it;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= {1'b0, val};
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == REG_PLANT_NOISE)
            noise_q = longint'(val);
        else if (idx == REG_SENSOR_NOISE)
            noise_r = longint'(val);
        else
            init_err = longint'(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_estimates.size() > 0 || in_valid)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        filter_item_t it;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_PREDICT;
        step_time = '0;
        measurement = '0;
        horizon = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PLANT_NOISE;
        cfg_data = '0;
        in_accept = 1'b0;
        errors = 0;
        accepted_items = 0;
        checked_results = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        hold_off = 0;
        floor_hits = 0;
        op_count = '{0, 0, 0, 0};
        pred_speed = 0;
        pred_rate = 0;
        pred_cov = '{ONE_Q, 0, 0, ONE_Q};
        noise_q = 655;
        noise_r = 65536;
        init_err = 65536;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items: field extremes, every mode, unused mode.
        pending_items.push_back(mk_item(MODE_PREDICT, 31'd65536, 32'sd0, 31'd65536));
        pending_items.push_back(mk_item(MODE_UPDATE, 31'd0, 32'sd327680, 31'd131072));
        pending_items.push_back(mk_item(MODE_PREDICT, 31'h7FFFFFFF, 32'sd0, 31'h7FFFFFFF));
        pending_items.push_back(mk_item(MODE_UPDATE, 31'h7FFFFFFF, 32'h80000000, 31'd0));
        pending_items.push_back(mk_item(MODE_UPDATE, 31'd0, 32'h7FFFFFFF, 31'h7FFFFFFF));
        pending_items.push_back(mk_item(2'd3, 31'h7FFFFFFF, 32'hFFFFFFFF, 31'd65536));
        pending_items.push_back(mk_item(MODE_RESTART, 31'd1, 32'sd1, 31'd1));
        pending_items.push_back(mk_item(MODE_PREDICT, 31'd1, 32'sd0, 31'd1));
        pending_items.push_back(mk_item(MODE_UPDATE, 31'd0, -32'sd65536, 31'd98304));
        drain();

        // Zero noise and zero initial error force the innovation floor.
        write_reg(REG_PLANT_NOISE, 31'd0);
        write_reg(REG_SENSOR_NOISE, 31'd0);
        write_reg(REG_INITIAL_ERROR, 31'd0);
        pending_items.push_back(mk_item(MODE_RESTART, 31'd0, 32'sd0, 31'd65536));
        pending_items.push_back(mk_item(MODE_UPDATE, 31'd0, 32'sd65536, 31'd65536));
        pending_items.push_back(mk_item(MODE_PREDICT, 31'd65536, 32'sd0, 31'd65536));
        pending_items.push_back(mk_item(MODE_UPDATE, 31'd0, -32'sd131072, 31'd65536));
        drain();

        // Maximum register values.
        write_reg(REG_PLANT_NOISE, 31'h7FFFFFFF);
        write_reg(REG_SENSOR_NOISE, 31'h7FFFFFFF);
        write_reg(REG_INITIAL_ERROR, 31'h7FFFFFFF);
        pending_items.push_back(mk_item(MODE_RESTART, 31'd0, 32'sd0, 31'd65536));
        pending_items.push_back(mk_item(MODE_PREDICT, 31'd65536, 32'sd0, 31'd65536));
        pending_items.push_back(mk_item(MODE_UPDATE, 31'd0, 32'sd6553600, 31'd65536));
        drain();

        // Random phases under several register settings.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_PLANT_NOISE, 31'(ph == 3 ? $urandom : $urandom_range(4000)));
            write_reg(REG_SENSOR_NOISE, 31'(ph == 2 ? $urandom : $urandom_range(200000)));
            write_reg(REG_INITIAL_ERROR, 31'($urandom_range(300000)));
            no_idle = (ph == 1);
            n = 500;
            for (int i = 0; i < n; i++)
            begin
                if (i % 60 == 0)
                    pending_items.push_back(mk_item(MODE_RESTART, 31'd0, 32'sd0, 31'd0));
                it = rand_item();
                pending_items.push_back(it);
            end
            // Long receiver hold-off while items keep coming.
            if (ph == 2)
            begin
                repeat (50) @(posedge clk);
                @(negedge clk);
                hold_off = 2000;
            end
            drain();
        end

        $display("Checked %0d results from %0d items: %0d predict, %0d update, %0d restart,",
                 checked_results, accepted_items, op_count[0], op_count[1], op_count[2]);
        $display("%0d unused-mode items, %0d floored innovations.", op_count[3], floor_hits);
        if (errors == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

FILE: kalman_filter_two_state_top.f
sv/kf2_pkg.sv
sv/kf2_datapath.sv
sv/kf2_ctrl.sv
sv/kalman_filter_two_state_top.sv
sv/kf2_checker.sv
dv/tb.sv
